### rtl/core/tcpu_pkg.sv
// Shared types and codes for the eight-bit teaching processor step block.
// No dependencies; imported by tcpu_alu and eight_bit_teaching_cpu_step.
package tcpu_pkg;

    localparam int DATA_W           = 8;
    localparam int MEMORY_BYTES_DEF = 256;

    // Item actions
    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Stop reasons
    localparam logic [1:0] STOP_NONE  = 2'd0;
    localparam logic [1:0] STOP_HALT  = 2'd1;
    localparam logic [1:0] STOP_BREAK = 2'd2;

    // Addressing modes
    localparam logic [1:0] MODE_DIRECT    = 2'd0;
    localparam logic [1:0] MODE_INDIRECT  = 2'd1;
    localparam logic [1:0] MODE_IMMEDIATE = 2'd2;
    localparam logic [1:0] MODE_INDEXED   = 2'd3;

    // Register codes
    localparam logic [1:0] REG_A  = 2'd0;
    localparam logic [1:0] REG_B  = 2'd1;
    localparam logic [1:0] REG_X  = 2'd2;
    localparam logic [1:0] REG_PC = 2'd3;

    typedef enum logic [3:0] {
        OPC_NOP = 4'd0,
        OPC_STR = 4'd1,
        OPC_LDR = 4'd2,
        OPC_ADD = 4'd3,
        OPC_OR  = 4'd4,
        OPC_AND = 4'd5,
        OPC_NOT = 4'd6,
        OPC_SUB = 4'd7,
        OPC_JMP = 4'd8,
        OPC_JN  = 4'd9,
        OPC_JZ  = 4'd10,
        OPC_JC  = 4'd11,
        OPC_JSR = 4'd12,
        OPC_NEG = 4'd13,
        OPC_SHR = 4'd14,
        OPC_HLT = 4'd15
    } opcode_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_OR,
        ALU_AND,
        ALU_NOT,
        ALU_NEG,
        ALU_SHR,
        ALU_PASSB
    } alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_OPERAND,
        S_INDIRECT,
        S_OPVAL,
        S_EXEC,
        S_WRITE,
        S_RDADDR,
        S_RDDATA,
        S_DONE
    } state_t;

    // Opcodes that carry an operand byte
    function automatic logic is_two_byte(input opcode_t opc);
        return ((opc >= OPC_STR) && (opc <= OPC_AND)) ||
               ((opc >= OPC_SUB) && (opc <= OPC_JSR));
    endfunction

endpackage

### rtl/core/tcpu_alu.sv
// Shared 8-bit arithmetic/logic unit of the teaching processor.
// Depends on tcpu_pkg for the operation codes.
module tcpu_alu (
    input  tcpu_pkg::alu_op_t op,
    input  logic [7:0]        a,
    input  logic [7:0]        b,
    output logic [8:0]        y
);
    import tcpu_pkg::*;

    // y[8] is carry for add, borrow for subtract, shifted-out bit for SHR
    always_comb
    begin
        case (op)
            ALU_ADD:   y = {1'b0, a} + {1'b0, b};
            ALU_SUB:   y = {1'b0, a} - {1'b0, b};
            ALU_OR:    y = {1'b0, a | b};
            ALU_AND:   y = {1'b0, a & b};
            ALU_NOT:   y = {1'b0, ~a};
            ALU_NEG:   y = {1'b0, (~a) + 8'd1};
            ALU_SHR:   y = {a[0], 1'b0, a[7:1]};
            ALU_PASSB: y = {1'b0, b};
            default:   y = '0;
        endcase
    end

endmodule

### rtl/core/eight_bit_teaching_cpu_step.sv
// Top level of the eight-bit teaching processor step block: sequencer,
// register file, byte memory with valid bits. Depends on tcpu_pkg, tcpu_alu.
//
// Each beat accepted on start (while busy is low) runs one instruction,
// writes one memory byte, reads one, or does nothing for an unused action.
// The result beat appears for exactly one cycle with done high and cannot
// be held off, so capture it on that edge.
// All work goes through a single memory port with registered read data
// and one shared ALU. An instruction steps through fetch, decode, operand
// (two-byte only), indirect (indirect mode only), operand value (two-byte
// only), execute and done; a memory write through write and done; a read
// through read address, read data and done; an unused action goes straight
// to done. The block returns to idle after each done before the next beat
// is taken. Memory reads as zero after reset through per-byte valid bits,
// so there is no clearing pass. Write breakpoint_wdata with breakpoint_we
// only while idle.
module eight_bit_teaching_cpu_step #(
    parameter int MEMORY_BYTES = tcpu_pkg::MEMORY_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] action,
    input  logic [7:0] address,
    input  logic [7:0] write_data,
    input  logic       breakpoint_we,
    input  logic [7:0] breakpoint_wdata,
    output logic       done,
    output logic [7:0] program_counter,
    output logic [7:0] reg_a,
    output logic [7:0] reg_b,
    output logic [7:0] reg_x,
    output logic       flag_negative,
    output logic       flag_zero,
    output logic       flag_carry,
    output logic [1:0] stop_reason,
    output logic [7:0] read_data
);
    import tcpu_pkg::*;

    localparam int          AW      = $clog2(MEMORY_BYTES);
    localparam logic [12:0] MEM_W13 = 13'(MEMORY_BYTES);

    // Reduce a 9-bit address modulo the memory size by restoring subtraction;
    // the quotient never exceeds five bits since the memory has 16+ bytes.
    function automatic logic [AW-1:0] mem_mod(input logic [8:0] v);
        logic [12:0] rem;
        rem = {4'b0000, v};
        for (int k = 4; k >= 0; k--)
        begin
            if (rem >= (MEM_W13 << k))
                rem = rem - (MEM_W13 << k);
        end
        return rem[AW-1:0];
    endfunction

    // Sequencer
    state_t state_reg, state_next;

    // Architectural state
    logic [7:0] pc_reg, pc_next;
    logic [7:0] a_reg, a_next;
    logic [7:0] b_reg, b_next;
    logic [7:0] x_reg, x_next;
    logic       n_reg, n_next;
    logic       z_reg, z_next;
    logic       c_reg, c_next;
    logic [7:0] bp_reg;

    // Per-item working registers (no reset)
    logic [1:0]    act_reg, act_next;
    logic [7:0]    addr_reg, addr_next;
    logic [7:0]    wdata_reg, wdata_next;
    logic [7:0]    ir_reg, ir_next;
    logic [AW-1:0] ea_reg, ea_next;
    logic [AW-1:0] jt_reg, jt_next;
    logic [7:0]    ov_reg, ov_next;
    logic [1:0]    stop_reg, stop_next;
    logic [7:0]    rdout_reg, rdout_next;

    // Memory port
    logic [7:0]    mem_array [MEMORY_BYTES];
    logic          valid_reg [MEMORY_BYTES];
    logic [7:0]    rd_mem_reg;
    logic          rd_valid_reg;
    logic [7:0]    mem_rdata;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    // Shared ALU
    alu_op_t    alu_op;
    logic [7:0] alu_a;
    logic [7:0] alu_b;
    logic [8:0] alu_y;

    // Instruction fields
    opcode_t    opc;
    logic [1:0] rsel;
    logic [1:0] mode;
    logic [7:0] rv;
    logic       wr_reg;

    tcpu_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign opc  = opcode_t'(ir_reg[7:4]);
    assign rsel = ir_reg[3:2];
    assign mode = ir_reg[1:0];

    // An unwritten byte reads as zero
    assign mem_rdata = rd_valid_reg ? rd_mem_reg : 8'h00;

    always_comb
    begin
        case (rsel)
            REG_A:   rv = a_reg;
            REG_B:   rv = b_reg;
            REG_X:   rv = x_reg;
            default: rv = pc_reg;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_EXEC:  state_next = S_FETCH;
                        ACT_WRITE: state_next = S_WRITE;
                        ACT_READ:  state_next = S_RDADDR;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_FETCH:    state_next = S_DECODE;
            S_DECODE:   state_next = is_two_byte(opcode_t'(mem_rdata[7:4])) ? S_OPERAND
                                                                           : S_EXEC;
            S_OPERAND:  state_next = (mode == MODE_INDIRECT) ? S_INDIRECT : S_OPVAL;
            S_INDIRECT: state_next = S_OPVAL;
            S_OPVAL:    state_next = S_EXEC;
            S_EXEC:     state_next = S_DONE;
            S_WRITE:    state_next = S_DONE;
            S_RDADDR:   state_next = S_RDDATA;
            S_RDDATA:   state_next = S_DONE;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_DONE);

        pc_next    = pc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        n_next     = n_reg;
        z_next     = z_reg;
        c_next     = c_reg;
        act_next   = act_reg;
        addr_next  = addr_reg;
        wdata_next = wdata_reg;
        ir_next    = ir_reg;
        ea_next    = ea_reg;
        jt_next    = jt_reg;
        ov_next    = ov_reg;
        stop_next  = stop_reg;
        rdout_next = rdout_reg;

        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;

        // Default use of the ALU: advance the program counter
        alu_op = ALU_ADD;
        alu_a  = pc_reg;
        alu_b  = 8'd1;
        wr_reg = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    addr_next  = address;
                    wdata_next = write_data;
                    stop_next  = STOP_NONE;
                    rdout_next = 8'h00;
                end
            end
            S_FETCH:
            begin
                mem_raddr = mem_mod({1'b0, pc_reg});
            end
            S_DECODE:
            begin
                ir_next   = mem_rdata;
                pc_next   = alu_y[7:0];
                mem_raddr = mem_mod({1'b0, alu_y[7:0]});
            end
            S_OPERAND:
            begin
                case (mode)
                    MODE_DIRECT:
                    begin
                        ea_next = mem_mod({1'b0, mem_rdata});
                        jt_next = ea_next;
                    end
                    MODE_INDIRECT:
                    begin
                        ea_next = mem_mod({1'b0, mem_rdata});
                    end
                    MODE_IMMEDIATE:
                    begin
                        // Jump target is the unwrapped operand address plus one
                        ea_next = mem_mod({1'b0, pc_reg});
                        jt_next = mem_mod(alu_y);
                    end
                    default:
                    begin
                        alu_a   = mem_rdata;
                        alu_b   = x_reg;
                        ea_next = mem_mod(alu_y);
                        jt_next = ea_next;
                    end
                endcase
                mem_raddr = ea_next;
            end
            S_INDIRECT:
            begin
                ea_next   = mem_mod({1'b0, mem_rdata});
                jt_next   = ea_next;
                mem_raddr = ea_next;
            end
            S_OPVAL:
            begin
                ov_next = mem_rdata;
                pc_next = alu_y[7:0];
            end
            S_EXEC:
            begin
                stop_next = (pc_reg == bp_reg) ? STOP_BREAK : STOP_NONE;
                alu_a     = rv;
                alu_b     = ov_reg;
                case (opc)
                    OPC_NOP: ;
                    OPC_STR:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = ea_reg;
                        mem_wdata = rv;
                    end
                    OPC_LDR:
                    begin
                        alu_op = ALU_PASSB;
                        c_next = 1'b0;
                        wr_reg = 1'b1;
                    end
                    OPC_ADD:
                    begin
                        alu_op = ALU_ADD;
                        c_next = alu_y[8];
                        wr_reg = 1'b1;
                    end
                    OPC_OR:
                    begin
                        alu_op = ALU_OR;
                        c_next = 1'b0;
                        wr_reg = 1'b1;
                    end
                    OPC_AND:
                    begin
                        alu_op = ALU_AND;
                        c_next = 1'b0;
                        wr_reg = 1'b1;
                    end
                    OPC_NOT:
                    begin
                        alu_op = ALU_NOT;
                        c_next = 1'b0;
                        wr_reg = 1'b1;
                    end
                    OPC_SUB:
                    begin
                        alu_op = ALU_SUB;
                        c_next = alu_y[8];
                        wr_reg = 1'b1;
                    end
                    OPC_JMP: pc_next = 8'(jt_reg);
                    OPC_JN:  pc_next = n_reg ? 8'(jt_reg) : pc_reg;
                    OPC_JZ:  pc_next = z_reg ? 8'(jt_reg) : pc_reg;
                    OPC_JC:  pc_next = c_reg ? 8'(jt_reg) : pc_reg;
                    OPC_JSR:
                    begin
                        // Store the return address, continue past the target
                        mem_we    = 1'b1;
                        mem_waddr = ea_reg;
                        mem_wdata = pc_reg;
                        alu_op    = ALU_ADD;
                        alu_a     = 8'(jt_reg);
                        alu_b     = 8'd1;
                        pc_next   = alu_y[7:0];
                    end
                    OPC_NEG:
                    begin
                        alu_op = ALU_NEG;
                        wr_reg = 1'b1;
                    end
                    OPC_SHR:
                    begin
                        alu_op = ALU_SHR;
                        c_next = alu_y[8];
                        wr_reg = 1'b1;
                    end
                    OPC_HLT: stop_next = STOP_HALT;
                    default: ;
                endcase
                if (wr_reg)
                begin
                    case (rsel)
                        REG_A:   a_next  = alu_y[7:0];
                        REG_B:   b_next  = alu_y[7:0];
                        REG_X:   x_next  = alu_y[7:0];
                        default: pc_next = alu_y[7:0];
                    endcase
                    n_next = alu_y[7];
                    z_next = (alu_y[7:0] == 8'h00);
                end
            end
            S_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = mem_mod({1'b0, addr_reg});
                mem_wdata = wdata_reg;
            end
            S_RDADDR:
            begin
                mem_raddr = mem_mod({1'b0, addr_reg});
            end
            S_RDDATA:
            begin
                rdout_next = mem_rdata;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // Control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= 8'h00;
            a_reg     <= 8'h00;
            b_reg     <= 8'h00;
            x_reg     <= 8'h00;
            n_reg     <= 1'b0;
            z_reg     <= 1'b1;
            c_reg     <= 1'b0;
            bp_reg    <= 8'h00;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            x_reg     <= x_next;
            n_reg     <= n_next;
            z_reg     <= z_next;
            c_reg     <= c_next;
            if (breakpoint_we)
                bp_reg <= breakpoint_wdata;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        addr_reg  <= addr_next;
        wdata_reg <= wdata_next;
        ir_reg    <= ir_next;
        ea_reg    <= ea_next;
        jt_reg    <= jt_next;
        ov_reg    <= ov_next;
        stop_reg  <= stop_next;
        rdout_reg <= rdout_next;
    end

    // Valid bits: drop all at reset, mark each byte on its first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MEMORY_BYTES; i++)
                valid_reg[i] <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                valid_reg[mem_waddr] <= 1'b1;
            rd_valid_reg <= valid_reg[mem_raddr];
        end
    end

    // Byte memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_array[mem_waddr] <= mem_wdata;
        rd_mem_reg <= mem_array[mem_raddr];
    end

    assign program_counter = pc_reg;
    assign reg_a           = a_reg;
    assign reg_b           = b_reg;
    assign reg_x           = x_reg;
    assign flag_negative   = n_reg;
    assign flag_zero       = z_reg;
    assign flag_carry      = c_reg;
    assign stop_reason     = stop_reg;
    assign read_data       = rdout_reg;

    // A result beat lasts exactly one cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // An accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // Only an executed instruction reports a stop
    a_stop_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (stop_reason != STOP_NONE)) |-> (act_reg == ACT_EXEC))
        else $error("stop reported for a memory access");

    // Read data is zero unless the beat was a read
    a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (act_reg != ACT_READ)) |-> (read_data == 8'h00))
        else $error("read data nonzero for a non-read beat");

endmodule
